@@ sv/psnr_pkg.sv @@
// ----------------------------------------------------------------------------
// psnr_pkg
// Types and fixed constants shared by the PSNR metric unit.
// ----------------------------------------------------------------------------
package psnr_pkg;

    // Field widths
    localparam int SAMPLE_W = 18;
    localparam int DIM_W    = 14;
    localparam int ACC_W    = 63;
    localparam int CNT_W    = 27;
    localparam int NPIX_W   = 2 * DIM_W;
    localparam int SQ_W     = 2 * (SAMPLE_W + 1);
    localparam int PSNR_W   = 20;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Base-2 logarithm: integer part (6 bits) and Q.24 fraction
    localparam int LOG_FRAC = 24;
    localparam int LOG_INT  = 6;
    localparam int LOG_W    = LOG_INT + LOG_FRAC;
    localparam int LOG_X_W  = 64;
    localparam int MANT_W   = 32;

    // dB scaling: 10*log10(2) in Q.28, product rounded to nearest at Q.8
    localparam int                  NUM_W             = LOG_W + 1;
    localparam int                  DB_W              = 30;
    localparam logic [DB_W-1:0]     DB_PER_OCTAVE_Q28 = 30'd808071242;
    localparam int                  PROD_W            = NUM_W + DB_W;
    localparam int                  SCALE_SHIFT       = LOG_FRAC + 28 - 8;
    localparam int                  Q_W               = PROD_W + 1 - SCALE_SHIFT;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int                CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        ST_FINITE    = 2'd0,
        ST_IDENTICAL = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    // One finished frame handed from the front end to the back end
    typedef struct packed {
        logic [ACC_W-1:0] esum;
        logic [CNT_W-1:0] npix;
        t_status          status;
    } t_frame;

    typedef struct packed {
        logic               start;
        logic [LOG_X_W-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_rsp;

endpackage

@@ sv/psnr_front.sv @@
// ----------------------------------------------------------------------------
// psnr_front
// Squares sample differences and accumulates them per frame; classifies a
// frame on its last word and pushes it to the frame queue.
// ----------------------------------------------------------------------------
module psnr_front import psnr_pkg::*; #(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_first_sample,
    input  logic [SAMPLE_W-1:0] i_second_sample,
    input  logic                i_last_pixel,
    input  logic [DIM_W-1:0]    i_image_width,
    input  logic [DIM_W-1:0]    i_image_height,
    output logic                o_push,
    output t_frame              o_frame,
    input  logic                i_q_ready
);

    localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);

    logic              r_s1_vld;
    logic              r_s1_last;
    logic [SQ_W-1:0]   r_sq;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [NPIX_W-1:0] r_npix;
    logic              r_dims_ok;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        mag;
    logic [SQ_W-1:0]          sq;
    logic [ACC_W:0]           sum;
    logic [ACC_W-1:0]         n_acc;
    logic [CNT_W-1:0]         n_cnt;
    logic                     s1_adv;
    logic                     consume;
    logic                     accept;

    always_comb begin
        diff = $signed({i_first_sample[SAMPLE_W-1], i_first_sample})
             - $signed({i_second_sample[SAMPLE_W-1], i_second_sample});
        mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
        sq   = SQ_W'(mag) * SQ_W'(mag);
    end

    // A last word may move on only if the queue has room for its frame
    assign s1_adv     = !r_s1_last || i_q_ready;
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign consume    = r_s1_vld && s1_adv;

    always_comb begin
        sum   = {1'b0, r_acc} + (ACC_W+1)'(r_sq);
        n_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);

        o_push       = consume && r_s1_last;
        o_frame.esum = n_acc;
        o_frame.npix = r_npix[CNT_W-1:0];
        if (!r_dims_ok || ((NPIX_W)'(n_cnt) != r_npix)) begin
            o_frame.status = ST_INVALID;
        end else if (n_acc == '0) begin
            o_frame.status = ST_IDENTICAL;
        end else begin
            o_frame.status = ST_FINITE;
        end
    end

    // Dimension product and check follow the configuration registers
    always_ff @(posedge i_clk) begin
        r_npix    <= NPIX_W'(i_image_width) * NPIX_W'(i_image_height);
        r_dims_ok <= (i_image_width != '0) && (i_image_height != '0)
                  && (32'(i_image_width) <= MAX_DIM) && (32'(i_image_height) <= MAX_DIM);
        if (accept) begin
            r_sq      <= sq;
            r_s1_last <= i_last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= accept;
            end
            if (consume) begin
                if (r_s1_last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

endmodule

@@ sv/psnr_queue.sv @@
// ----------------------------------------------------------------------------
// psnr_queue
// Short queue of finished frames between front end and back end.
// ----------------------------------------------------------------------------
module psnr_queue import psnr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_ready,
    output logic   o_valid,
    output t_frame o_frame,
    input  logic   i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_frame          r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_frame = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

@@ sv/psnr_log2.sv @@
// ----------------------------------------------------------------------------
// psnr_log2
// Iterative base-2 logarithm in Q.24: normalize, then one fraction bit per
// squaring step.
// ----------------------------------------------------------------------------
module psnr_log2 import psnr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_log_req i_req,
    output t_log_rsp o_rsp
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_MUL,
        L_UPD
    } t_state;

    t_state                    r_state;
    logic [LOG_X_W-1:0]        r_x;
    logic [LOG_INT-1:0]        r_p;
    logic [MANT_W-1:0]         r_m;
    logic [2*MANT_W-1:0]       r_prod;
    logic [LOG_FRAC-1:0]       r_frac;
    logic [$clog2(LOG_FRAC)-1:0] r_bit;
    logic                      r_done;
    logic [MANT_W:0]           sq_top;

    assign sq_top      = r_prod[2*MANT_W-1:MANT_W-1];
    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_p, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    // drop the done pulse in the cycle after it rose
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_x     <= i_req.x;
                        r_p     <= LOG_INT'(LOG_X_W - 1);
                        r_frac  <= '0;
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    // shift by a byte while the top byte is empty, then bit by bit
                    if (r_x[LOG_X_W-1]) begin
                        r_m     <= r_x[LOG_X_W-1 -: MANT_W];
                        r_bit   <= ($clog2(LOG_FRAC))'(LOG_FRAC - 1);
                        r_state <= L_MUL;
                    end else if (r_x[LOG_X_W-1 -: 8] == '0) begin
                        r_x <= r_x << 8;
                        r_p <= r_p - LOG_INT'(8);
                    end else begin
                        r_x <= r_x << 1;
                        r_p <= r_p - LOG_INT'(1);
                    end
                end
                L_MUL: begin
                    r_prod  <= r_m * r_m;
                    r_state <= L_UPD;
                end
                L_UPD: begin
                    if (sq_top[MANT_W]) begin
                        r_m           <= sq_top[MANT_W:1];
                        r_frac[r_bit] <= 1'b1;
                    end else begin
                        r_m <= sq_top[MANT_W-1:0];
                    end
                    if (r_bit == '0) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end else begin
                        r_bit   <= r_bit - ($clog2(LOG_FRAC))'(1);
                        r_state <= L_MUL;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

endmodule

@@ sv/psnr_back.sv @@
// ----------------------------------------------------------------------------
// psnr_back
// Takes frames from the queue, runs both logarithms for finite frames, scales
// to dB and holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module psnr_back import psnr_pkg::*; #(
    parameter int SAMPLE_FRACTION_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_frame            i_frame,
    output logic              o_q_pop,
    output t_log_req          o_log_req,
    input  t_log_rsp          i_log_rsp,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PSNR_W-1:0] o_psnr_db,
    output logic [ACC_W-1:0]  o_error_sum,
    output logic [1:0]        o_status
);

    localparam logic [NUM_W-1:0] NUM_OFFSET =
        NUM_W'(longint'(2 * SAMPLE_FRACTION_BITS) << LOG_FRAC);
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (SCALE_SHIFT - 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOGN,
        B_WAITN,
        B_LOGE,
        B_WAITE,
        B_MUL,
        B_ROUND,
        B_EMIT
    } t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_esum;
    logic [CNT_W-1:0]    r_npix;
    t_status             r_status;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_diff;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [PSNR_W-1:0]   r_psnr;
    logic                r_out_vld;
    logic [PSNR_W-1:0]   r_out_psnr;
    logic [ACC_W-1:0]    r_out_esum;
    t_status             r_out_status;

    logic [NUM_W-1:0]    den;
    logic [PROD_W:0]     rnd;
    logic [Q_W-1:0]      q;

    always_comb begin
        o_q_pop         = (r_state == B_IDLE) && i_q_valid;
        o_log_req.start = (r_state == B_LOGN) || (r_state == B_LOGE);
        o_log_req.x     = (r_state == B_LOGE) ? LOG_X_W'(r_esum) : LOG_X_W'(r_npix);
        den             = NUM_W'(i_log_rsp.value);
        rnd             = (PROD_W+1)'(r_prod) + ROUND_HALF;
        q               = rnd[PROD_W:SCALE_SHIFT];
    end

    assign o_out_valid = r_out_vld;
    assign o_psnr_db   = r_out_psnr;
    assign o_error_sum = r_out_esum;
    assign o_status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // a taken word is dropped here unless the emit state reloads it
            if (i_out_ready && (r_state != B_EMIT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_esum   <= i_frame.esum;
                        r_npix   <= i_frame.npix;
                        r_status <= i_frame.status;
                        r_psnr   <= '0;
                        r_state  <= (i_frame.status == ST_FINITE) ? B_LOGN : B_EMIT;
                    end
                end
                B_LOGN:  r_state <= B_WAITN;
                B_WAITN: begin
                    if (i_log_rsp.done) begin
                        r_num   <= NUM_W'(i_log_rsp.value) + NUM_OFFSET;
                        r_state <= B_LOGE;
                    end
                end
                B_LOGE:  r_state <= B_WAITE;
                B_WAITE: begin
                    if (i_log_rsp.done) begin
                        r_neg   <= den > r_num;
                        r_diff  <= (den > r_num) ? den - r_num : r_num - den;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= PROD_W'(r_diff) * PROD_W'(DB_PER_OCTAVE_Q28);
                    r_state <= B_ROUND;
                end
                B_ROUND: begin
                    // magnitude stays far below the Q11.8 limit for these widths
                    r_psnr  <= r_neg ? PSNR_W'(-PSNR_W'(q)) : PSNR_W'(q);
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_psnr   <= r_psnr;
                        r_out_esum   <= r_esum;
                        r_out_status <= r_status;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ sv/psnr_metric_unit.sv @@
// ----------------------------------------------------------------------------
// psnr_metric_unit
// Streaming PSNR between two images given as paired Q3.14 samples.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock, squares the difference and adds it
// to a saturating 63-bit sum (Q35.28); on the word marked last it produces one
// result word: PSNR = 10*log10(width*height/error) in dB as signed Q11.8, the
// error sum, and a status (finite, identical images, or invalid dimensions or
// pixel count). Pairs are accepted at one per cycle without pause while the
// frame queue has room. For a finite result the back end runs the two base-2
// logarithms one after the other on a single iterative unit (normalizing, then
// one squaring step per fraction bit, for each logarithm) and then a scaling
// multiply; invalid and identical frames skip that work. A result word held
// off by the consumer adds its stall to the frames behind it. The queue holds
// two finished frames, so input stalls only when frames shorter than the
// back-end time arrive back to back, or while results are held off. Image
// width and height are to be written through the configuration port only
// while the unit is idle, which the unit itself does not enforce; both reset
// to 1.
// ----------------------------------------------------------------------------
module psnr_metric_unit import psnr_pkg::*; #(
    parameter int MAX_DIMENSION        = 8192,
    parameter int SAMPLE_FRACTION_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    // pixel pair words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SAMPLE_W-1:0]  i_first_sample,
    input  logic [SAMPLE_W-1:0]  i_second_sample,
    input  logic                 i_last_pixel,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PSNR_W-1:0]    o_psnr_db,
    output logic [ACC_W-1:0]     o_error_sum,
    output logic [1:0]           o_status
);

    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;

    logic     push;
    t_frame   push_frame;
    logic     q_ready;
    logic     q_valid;
    t_frame   q_frame;
    logic     q_pop;
    t_log_req log_req;
    t_log_rsp log_rsp;

    // Configuration registers; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: square, accumulate, classify the frame on its last word
    psnr_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_last_pixel    (i_last_pixel),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .o_push          (push),
        .o_frame         (push_frame),
        .i_q_ready       (q_ready)
    );

    // Hold finished frames so the front end keeps streaming
    psnr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_frame (q_frame),
        .i_pop   (q_pop)
    );

    // Shared logarithm unit, used for a finite frame once for the pixel count, once for the error
    psnr_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_rsp   (log_rsp)
    );

    // Back end: logarithms, dB scaling and the result register
    psnr_back #(
        .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_frame     (q_frame),
        .o_q_pop     (q_pop),
        .o_log_req   (log_req),
        .i_log_rsp   (log_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_psnr_db   (o_psnr_db),
        .o_error_sum (o_error_sum),
        .o_status    (o_status)
    );

endmodule
